/* hdl/brs_pkg.sv */
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants, codes and types of the bitmap range and run search block.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int WORD_COUNT = 64;
  localparam int WORD_BITS  = 64;
  localparam int TOTAL_BITS = WORD_COUNT * WORD_BITS;

  localparam int POS_W   = $clog2(WORD_BITS);
  localparam int CNT_W   = POS_W + 1;
  localparam int ADDR_W  = $clog2(WORD_COUNT);
  localparam int KIND_W  = 3;
  localparam int BIT_W   = 12;
  localparam int TOTAL_W = 13;
  localparam int WSEL_W  = 6;
  localparam int SUM_W   = TOTAL_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET     = 3'd0,
    KIND_CLEAR   = 3'd1,
    KIND_TEST    = 3'd2,
    KIND_SRCH_UP = 3'd3,
    KIND_SRCH_DN = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETCLR,
    ST_TEST,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  // word read in flight
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } beat_tag_t;

  // per-word summary used by the run search
  typedef struct packed {
    beat_tag_t        tag;
    logic             all_ones;
    logic [CNT_W-1:0] lo_ones;
    logic [CNT_W-1:0] hi_ones;
    logic             win_any;
    logic [POS_W-1:0] win_lo;
    logic [POS_W-1:0] win_hi;
  } word_feat_t;

endpackage

/* hdl/brs_req_if.sv */
// ----------------------------------------------------------------------------
// brs_req_if
// Request channel of the bitmap block: valid/ready and one request beat.
// ----------------------------------------------------------------------------
interface brs_req_if;
  logic                         valid;
  logic                         ready;
  logic [brs_pkg::KIND_W-1:0]   kind;
  logic [brs_pkg::BIT_W-1:0]    bit_index;
  logic [brs_pkg::TOTAL_W-1:0]  bit_total;
  logic [brs_pkg::WSEL_W-1:0]   first_word;
  logic [brs_pkg::WSEL_W-1:0]   last_word;

  modport source (
    output valid, kind, bit_index, bit_total, first_word, last_word,
    input  ready
  );
  modport sink (
    input  valid, kind, bit_index, bit_total, first_word, last_word,
    output ready
  );
endinterface

/* hdl/brs_rsp_if.sv */
// ----------------------------------------------------------------------------
// brs_rsp_if
// Response channel of the bitmap block: valid/ready and one result beat.
// ----------------------------------------------------------------------------
interface brs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       bit_value;
  logic                       run_found;
  logic [brs_pkg::BIT_W-1:0]  run_start;
  logic                       bad_request;

  modport source (
    output valid, bit_value, run_found, run_start, bad_request,
    input  ready
  );
  modport sink (
    input  valid, bit_value, run_found, run_start, bad_request,
    output ready
  );
endinterface

/* hdl/brs_word_scan.sv */
// ----------------------------------------------------------------------------
// brs_word_scan
// Registered summary of one bitmap word: ones at each end and the lowest and
// highest start of an in-word window of run_len ones.
// ----------------------------------------------------------------------------
module brs_word_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  brs_pkg::beat_tag_t           tag,
  input  logic [brs_pkg::WORD_BITS-1:0] word,
  input  logic [brs_pkg::TOTAL_W-1:0]  run_len,
  output brs_pkg::word_feat_t          feat_r
);

  brs_pkg::word_feat_t feat_nxt;

  always_comb begin
    logic [brs_pkg::WORD_BITS-1:0] win;
    logic [brs_pkg::CNT_W-1:0]     len;
    logic [brs_pkg::CNT_W-1:0]     span;
    logic [brs_pkg::POS_W-1:0]     lo_zero;
    logic [brs_pkg::POS_W-1:0]     hi_zero;
    logic [brs_pkg::POS_W-1:0]     w_lo;
    logic [brs_pkg::POS_W-1:0]     w_hi;

    len  = run_len[brs_pkg::CNT_W-1:0];
    // windows by doubling, then one overlapping step for the remainder
    win  = word;
    span = brs_pkg::CNT_W'(1);
    for (int k = 0; k < brs_pkg::POS_W; k++) begin
      if (len >= (brs_pkg::CNT_W'(2) << k)) begin
        win  = win & (win >> (1 << k));
        span = brs_pkg::CNT_W'(2) << k;
      end
    end
    win = win & (win >> (len - span));

    lo_zero = '0;
    for (int i = brs_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        lo_zero = brs_pkg::POS_W'(i);
      end
    end
    hi_zero = '0;
    for (int i = 0; i < brs_pkg::WORD_BITS; i++) begin
      if (!word[i]) begin
        hi_zero = brs_pkg::POS_W'(i);
      end
    end
    w_lo = '0;
    for (int i = brs_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (win[i]) begin
        w_lo = brs_pkg::POS_W'(i);
      end
    end
    w_hi = '0;
    for (int i = 0; i < brs_pkg::WORD_BITS; i++) begin
      if (win[i]) begin
        w_hi = brs_pkg::POS_W'(i);
      end
    end

    feat_nxt.tag      = tag;
    feat_nxt.all_ones = &word;
    feat_nxt.lo_ones  = (&word) ? brs_pkg::CNT_W'(brs_pkg::WORD_BITS)
                                : {1'b0, lo_zero};
    feat_nxt.hi_ones  = (&word) ? brs_pkg::CNT_W'(brs_pkg::WORD_BITS)
                                : brs_pkg::CNT_W'(brs_pkg::WORD_BITS - 1) - {1'b0, hi_zero};
    feat_nxt.win_any  = |win;
    feat_nxt.win_lo   = w_lo;
    feat_nxt.win_hi   = w_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_r.tag.vld <= 1'b0;
    end else begin
      feat_r <= feat_nxt;
    end
  end

endmodule

/* hdl/bitmap_range_and_run_search.sv */
// ----------------------------------------------------------------------------
// bitmap_range_and_run_search
// Bitmap of 64 words of 64 bits with range set/clear, bit test and search
// for a run of consecutive ones, upward or downward over a word range.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one response. The bitmap sits
// in a single-port-read, single-port-write memory read one word per cycle,
// so the cost is set by the number of words walked: set or clear walks the
// words spanned, a bit test one word, and a search the words scanned up to
// the hit (at most last_word - first_word + 1). Rejected requests read no
// words. The response sits in an output register; a new request is taken
// once the previous result has moved there. The bitmap reads as all zero
// after reset with no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_range_and_run_search (
  input  logic      clk,
  input  logic      rst_n,
  brs_req_if.sink   in_req,
  brs_rsp_if.source out_rsp
);

  localparam int AW = brs_pkg::ADDR_W;
  localparam int PW = brs_pkg::POS_W;
  localparam int BW = brs_pkg::BIT_W;
  localparam int TW = brs_pkg::TOTAL_W;
  localparam int SW = brs_pkg::SUM_W;
  localparam int WB = brs_pkg::WORD_BITS;

  // bitmap storage
  logic [WB-1:0]                 bitmap_mem [brs_pkg::WORD_COUNT];
  logic [brs_pkg::WORD_COUNT-1:0] entry_vld_r;
  logic [WB-1:0]                 rd_data_r;
  logic                          rd_ok_r;

  brs_pkg::state_t    state_r, state_nxt;
  brs_pkg::beat_tag_t s1_tag_r, s1_tag_nxt;
  brs_pkg::word_feat_t feat;

  logic          set_r, set_nxt;
  logic          dn_r, dn_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] lo_bit_r, lo_bit_nxt;
  logic [PW-1:0] hi_bit_r, hi_bit_nxt;
  logic [AW-1:0] ws_r, ws_nxt;
  logic [AW-1:0] we_r, we_nxt;
  logic [AW-1:0] iss_addr_r, iss_addr_nxt;
  logic [AW-1:0] iss_end_r, iss_end_nxt;
  logic          iss_on_r, iss_on_nxt;
  logic [TW-1:0] run_r, run_nxt;
  logic [BW-1:0] run_lo_r, run_lo_nxt;

  logic          res_bit_r, res_bit_nxt;
  logic          res_found_r, res_found_nxt;
  logic [BW-1:0] res_start_r, res_start_nxt;
  logic          res_bad_r, res_bad_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_bit_r, out_bit_nxt;
  logic          out_found_r, out_found_nxt;
  logic [BW-1:0] out_start_r, out_start_nxt;
  logic          out_bad_r, out_bad_nxt;

  logic          in_fire;
  logic          rd_en;
  logic          wr_en;
  logic [WB-1:0] wr_data;
  logic [WB-1:0] s1_word;
  logic [SW-1:0] range_sum;
  logic [SW-1:0] range_last;

  assign in_req.ready = (state_r == brs_pkg::ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign s1_word      = rd_ok_r ? rd_data_r : '0;
  assign range_sum    = SW'(in_req.bit_index) + SW'(in_req.bit_total);
  assign range_last   = range_sum - SW'(1);

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.bit_value   = out_bit_r;
  assign out_rsp.run_found   = out_found_r;
  assign out_rsp.run_start   = out_start_r;
  assign out_rsp.bad_request = out_bad_r;

  brs_word_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag     (s1_tag_r),
    .word    (s1_word),
    .run_len (cnt_r),
    .feat_r  (feat)
  );

  always_comb begin
    logic          bad;
    logic [PW-1:0] m_lo;
    logic [PW-1:0] m_hi;
    logic [WB-1:0] mask;
    logic [SW-1:0] carry_sum;
    logic          hit_carry;
    logic          hit_win;
    logic [BW-1:0] word_base;
    logic [SW-1:0] dn_start;

    state_nxt     = state_r;
    set_nxt       = set_r;
    dn_nxt        = dn_r;
    cnt_nxt       = cnt_r;
    lo_bit_nxt    = lo_bit_r;
    hi_bit_nxt    = hi_bit_r;
    ws_nxt        = ws_r;
    we_nxt        = we_r;
    iss_addr_nxt  = iss_addr_r;
    iss_end_nxt   = iss_end_r;
    iss_on_nxt    = iss_on_r;
    run_nxt       = run_r;
    run_lo_nxt    = run_lo_r;
    res_bit_nxt   = res_bit_r;
    res_found_nxt = res_found_r;
    res_start_nxt = res_start_r;
    res_bad_nxt   = res_bad_r;
    out_bit_nxt   = out_bit_r;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;
    out_bad_nxt   = out_bad_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    wr_en         = 1'b0;
    wr_data       = '0;
    bad           = 1'b0;

    // mask of the bits of the current word inside the set/clear range
    m_lo = (s1_tag_r.addr == ws_r) ? lo_bit_r : '0;
    m_hi = (s1_tag_r.addr == we_r) ? hi_bit_r : PW'(WB - 1);
    mask = ({WB{1'b1}} << m_lo) & ({WB{1'b1}} >> (PW'(WB - 1) - m_hi));

    // run search step on the summarised word
    word_base = BW'({feat.tag.addr, PW'(0)});
    carry_sum = SW'(run_r) + SW'(dn_r ? feat.hi_ones : feat.lo_ones);
    hit_carry = (run_r != '0) && (carry_sum >= SW'(cnt_r));
    hit_win   = (cnt_r <= TW'(WB)) && feat.win_any;
    dn_start  = SW'(word_base) + SW'(WB) + SW'(run_r) - SW'(cnt_r);

    // word reads, one per cycle while a request is being walked
    rd_en = iss_on_r && (state_r == brs_pkg::ST_SETCLR || state_r == brs_pkg::ST_TEST ||
                         state_r == brs_pkg::ST_SEARCH);
    s1_tag_nxt.vld  = rd_en;
    s1_tag_nxt.last = (iss_addr_r == iss_end_r);
    s1_tag_nxt.addr = iss_addr_r;
    if (rd_en) begin
      iss_on_nxt   = (iss_addr_r != iss_end_r);
      iss_addr_nxt = dn_r ? iss_addr_r - AW'(1) : iss_addr_r + AW'(1);
    end

    case (state_r)
      brs_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_bit_nxt   = 1'b0;
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          cnt_nxt       = in_req.bit_total;
          lo_bit_nxt    = in_req.bit_index[PW-1:0];
          hi_bit_nxt    = range_last[PW-1:0];
          ws_nxt        = AW'(in_req.bit_index >> PW);
          we_nxt        = AW'(range_last >> PW);
          run_nxt       = '0;
          run_lo_nxt    = '0;
          dn_nxt        = 1'b0;
          iss_on_nxt    = 1'b1;
          iss_addr_nxt  = AW'(in_req.bit_index >> PW);
          iss_end_nxt   = AW'(range_last >> PW);
          set_nxt       = (brs_pkg::kind_t'(in_req.kind) == brs_pkg::KIND_SET);
          case (brs_pkg::kind_t'(in_req.kind))
            brs_pkg::KIND_SET, brs_pkg::KIND_CLEAR: begin
              bad       = (in_req.bit_total == '0) ||
                          (32'(range_sum) > brs_pkg::TOTAL_BITS);
              state_nxt = brs_pkg::ST_SETCLR;
            end
            brs_pkg::KIND_TEST: begin
              bad         = (32'(in_req.bit_index) >= brs_pkg::TOTAL_BITS);
              iss_end_nxt = AW'(in_req.bit_index >> PW);
              state_nxt   = brs_pkg::ST_TEST;
            end
            brs_pkg::KIND_SRCH_UP, brs_pkg::KIND_SRCH_DN: begin
              bad = (in_req.bit_total == '0) ||
                    (32'(in_req.last_word) >= brs_pkg::WORD_COUNT) ||
                    (in_req.first_word > in_req.last_word);
              dn_nxt       = (brs_pkg::kind_t'(in_req.kind) == brs_pkg::KIND_SRCH_DN);
              iss_addr_nxt = dn_nxt ? AW'(in_req.last_word) : AW'(in_req.first_word);
              iss_end_nxt  = dn_nxt ? AW'(in_req.first_word) : AW'(in_req.last_word);
              state_nxt    = brs_pkg::ST_SEARCH;
            end
            default: begin
              bad = 1'b1;
            end
          endcase
          res_bad_nxt = bad;
          if (bad) begin
            iss_on_nxt = 1'b0;
            state_nxt  = brs_pkg::ST_EMIT;
          end
        end
      end
      brs_pkg::ST_SETCLR: begin
        if (s1_tag_r.vld) begin
          wr_en   = 1'b1;
          wr_data = set_r ? (s1_word | mask) : (s1_word & ~mask);
          if (s1_tag_r.last) begin
            state_nxt = brs_pkg::ST_EMIT;
          end
        end
      end
      brs_pkg::ST_TEST: begin
        if (s1_tag_r.vld) begin
          res_bit_nxt = s1_word[lo_bit_r];
          state_nxt   = brs_pkg::ST_EMIT;
        end
      end
      brs_pkg::ST_SEARCH: begin
        if (feat.tag.vld) begin
          if (hit_carry || hit_win) begin
            res_found_nxt = 1'b1;
            if (hit_carry) begin
              res_start_nxt = dn_r ? dn_start[BW-1:0] : run_lo_r;
            end else begin
              res_start_nxt = word_base | BW'(dn_r ? feat.win_hi : feat.win_lo);
            end
            iss_on_nxt = 1'b0;
            state_nxt  = brs_pkg::ST_EMIT;
          end else begin
            if (feat.all_ones) begin
              // whole word extends the run
              run_nxt = run_r + TW'(WB);
              if (run_r == '0) begin
                run_lo_nxt = word_base;
              end
            end else if (dn_r) begin
              run_nxt = TW'(feat.lo_ones);
            end else begin
              run_nxt    = TW'(feat.hi_ones);
              run_lo_nxt = word_base + BW'(WB) - BW'(feat.hi_ones);
            end
            if (feat.tag.last) begin
              iss_on_nxt = 1'b0;
              state_nxt  = brs_pkg::ST_EMIT;
            end
          end
        end
      end
      brs_pkg::ST_EMIT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = res_bit_r;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = brs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brs_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= brs_pkg::ST_IDLE;
      s1_tag_r.vld <= 1'b0;
      iss_on_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      entry_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      s1_tag_r    <= s1_tag_nxt;
      iss_on_r    <= iss_on_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        entry_vld_r[s1_tag_r.addr] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    set_r       <= set_nxt;
    dn_r        <= dn_nxt;
    cnt_r       <= cnt_nxt;
    lo_bit_r    <= lo_bit_nxt;
    hi_bit_r    <= hi_bit_nxt;
    ws_r        <= ws_nxt;
    we_r        <= we_nxt;
    iss_addr_r  <= iss_addr_nxt;
    iss_end_r   <= iss_end_nxt;
    run_r       <= run_nxt;
    run_lo_r    <= run_lo_nxt;
    res_bit_r   <= res_bit_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    res_bad_r   <= res_bad_nxt;
    out_bit_r   <= out_bit_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // word memory, read data registered; never-written words read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap_mem[s1_tag_r.addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= bitmap_mem[iss_addr_r];
      rd_ok_r   <= entry_vld_r[iss_addr_r];
    end
  end

endmodule
